[sv/ipv4_dotted_quad_checker_macros.svh]
// Assertion macros shared by the checker of the dotted-quad address checker.
// No dependencies.
`ifndef IPV4_DOTTED_QUAD_CHECKER_MACROS_SVH
`define IPV4_DOTTED_QUAD_CHECKER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IPV4DQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define IPV4DQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[sv/ipv4dq_pkg.sv]
// Package of the dotted-quad address checker: constants, codes and types.
// Used by ipv4dq_field_parser and ipv4_dotted_quad_checker.
package ipv4dq_pkg;

  localparam int MAX_FIELD_CHARS = 4;
  localparam int CHAR_CNT_W = $clog2(MAX_FIELD_CHARS + 1);
  localparam int VAL_W = 9;
  localparam int ACC_W = VAL_W + 4;
  localparam logic [VAL_W-1:0] VALUE_CAP = 9'd256;
  localparam logic [VAL_W-1:0] OCTET_MAX = 9'd255;

  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_DOT = 8'h2E;
  localparam logic [7:0] CHAR_0 = 8'h30;
  localparam logic [7:0] CHAR_1 = 8'h31;
  localparam logic [7:0] CHAR_7 = 8'h37;
  localparam logic [7:0] CHAR_9 = 8'h39;
  localparam logic [7:0] CHAR_UA = 8'h41;
  localparam logic [7:0] CHAR_UF = 8'h46;
  localparam logic [7:0] CHAR_UX = 8'h58;
  localparam logic [7:0] CHAR_LA = 8'h61;
  localparam logic [7:0] CHAR_LF = 8'h66;
  localparam logic [7:0] CHAR_LX = 8'h78;

  typedef enum logic [2:0] {
    MODE_START = 3'd0,
    MODE_ZERO  = 3'd1,
    MODE_XWAIT = 3'd2,
    MODE_HEX   = 3'd3,
    MODE_OCT   = 3'd4,
    MODE_DEC   = 3'd5,
    MODE_BAD   = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    FERR_NONE  = 2'd0,
    FERR_LEAD  = 2'd1,
    FERR_DIGIT = 2'd2,
    FERR_RANGE = 2'd3
  } ferr_e;

  typedef enum logic [2:0] {
    KIND_OK     = 3'd0,
    KIND_STRUCT = 3'd1,
    KIND_LEAD   = 3'd2,
    KIND_DIGIT  = 3'd3,
    KIND_RANGE  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    BASE_OCT = 2'd0,
    BASE_DEC = 2'd1,
    BASE_HEX = 2'd2
  } base_e;

  typedef struct packed {
    mode_e            mode;
    logic [VAL_W-1:0] value;
    ferr_e            err;
  } field_step_t;

endpackage

[sv/ipv4dq_field_parser.sv]
// Per-character field parser: base detection, digit legality and saturating accumulation.
// Depends on ipv4dq_pkg.
module ipv4dq_field_parser import ipv4dq_pkg::*; (
  input  mode_e            mode_i,
  input  logic [VAL_W-1:0] value_i,
  input  logic [7:0]       char_i,
  output field_step_t      step_o
);

  function automatic logic [VAL_W-1:0] accumulate(input logic [VAL_W-1:0] v,
                                                  input base_e base,
                                                  input logic [3:0] digit);
    logic [ACC_W-1:0] wide;
    logic [ACC_W-1:0] sum;
    wide = ACC_W'(v);
    unique case (base)
      BASE_OCT: sum = (wide << 3) + ACC_W'(digit);
      BASE_DEC: sum = (wide << 3) + (wide << 1) + ACC_W'(digit);
      BASE_HEX: sum = (wide << 4) + ACC_W'(digit);
      default:  sum = wide;
    endcase
    accumulate = (sum > ACC_W'(VALUE_CAP)) ? VALUE_CAP : sum[VAL_W-1:0];
  endfunction

  logic       is_dec;
  logic       is_oct;
  logic       is_lhex;
  logic       is_uhex;
  logic       is_hex;
  logic [3:0] hex_val;
  logic [3:0] dec_val;

  assign is_dec  = (char_i >= CHAR_0) && (char_i <= CHAR_9);
  assign is_oct  = (char_i >= CHAR_0) && (char_i <= CHAR_7);
  assign is_lhex = (char_i >= CHAR_LA) && (char_i <= CHAR_LF);
  assign is_uhex = (char_i >= CHAR_UA) && (char_i <= CHAR_UF);
  assign is_hex  = is_dec || is_lhex || is_uhex;
  assign dec_val = 4'(char_i - CHAR_0);

  always_comb begin
    priority if (is_lhex) begin
      hex_val = 4'(char_i - CHAR_LA + 8'd10);
    end else if (is_uhex) begin
      hex_val = 4'(char_i - CHAR_UA + 8'd10);
    end else begin
      hex_val = dec_val;
    end
  end

  always_comb begin
    step_o.mode  = mode_i;
    step_o.value = value_i;
    step_o.err   = FERR_NONE;
    unique case (mode_i)
      MODE_START: begin
        if (char_i == CHAR_0) begin
          step_o.mode  = MODE_ZERO;
          step_o.value = '0;
        end else if ((char_i >= CHAR_1) && (char_i <= CHAR_9)) begin
          step_o.mode  = MODE_DEC;
          step_o.value = VAL_W'(dec_val);
        end else begin
          step_o.mode = MODE_BAD;
          step_o.err  = FERR_LEAD;
        end
      end
      MODE_ZERO: begin
        if ((char_i == CHAR_LX) || (char_i == CHAR_UX)) begin
          step_o.mode = MODE_XWAIT;
        end else if (is_oct) begin
          step_o.mode  = MODE_OCT;
          step_o.value = accumulate(value_i, BASE_OCT, dec_val);
        end else begin
          step_o.mode = MODE_BAD;
          step_o.err  = FERR_DIGIT;
        end
      end
      MODE_XWAIT, MODE_HEX: begin
        if (is_hex) begin
          step_o.mode  = MODE_HEX;
          step_o.value = accumulate(value_i, BASE_HEX, hex_val);
        end else begin
          step_o.mode = MODE_BAD;
          step_o.err  = FERR_DIGIT;
        end
      end
      MODE_OCT: begin
        if (is_oct) begin
          step_o.value = accumulate(value_i, BASE_OCT, dec_val);
        end else begin
          step_o.mode = MODE_BAD;
          step_o.err  = FERR_DIGIT;
        end
      end
      MODE_DEC: begin
        if (is_dec) begin
          step_o.value = accumulate(value_i, BASE_DEC, dec_val);
        end else begin
          step_o.mode = MODE_BAD;
          step_o.err  = FERR_DIGIT;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[sv/ipv4_dotted_quad_checker.sv]
// Top level of the dotted-quad address checker: parser state, octet store, result register.
// Depends on ipv4dq_pkg and ipv4dq_field_parser.
//
// Channel   Dir  tdata (low bit up)                                       tlast
// s_axis    in   char_code[7:0]                                           end_of_string
// m_axis    out  is_valid, error_kind[2:0], octet_first..octet_fourth,    none
//                four zero pad bits
//
// A new input transaction is accepted each cycle while s_axis_tready_o is high.
// An end transaction (tlast or a zero byte) loads the verdict into the result
// register, visible on the cycle after acceptance.
// Input is refused only while a verdict waits and m_axis_tready_i is low.
// Reset clears the parser state and the result valid flag; the result data is not reset.
module ipv4_dotted_quad_checker import ipv4dq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // char_code[7:0]
  input  logic        s_axis_tlast_i,  // end_of_string
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o   // is_valid, error_kind[2:0], octets 1..4, pad
);

  logic [1:0]            fn_q, fn_d;
  logic [CHAR_CNT_W-1:0] chars_q, chars_d;
  logic                  sf_q, sf_d;
  ferr_e                 ferr_q, ferr_d;
  mode_e                 mode_q, mode_d;
  logic [VAL_W-1:0]      value_q, value_d;
  logic [7:0]            oct_q [4];
  logic [7:0]            oct_d [4];
  logic                  out_valid_q, out_valid_d;
  logic [39:0]           out_data_q, out_data_d;

  field_step_t           step;
  logic                  accept;
  logic                  is_end;
  ferr_e                 close_err;
  ferr_e                 ferr_close;
  logic                  sf_end;
  kind_e                 kind;
  logic [7:0]            oct_out [4];

  ipv4dq_field_parser u_parser (
    .mode_i  (mode_q),
    .value_i (value_q),
    .char_i  (s_axis_tdata_i),
    .step_o  (step)
  );

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign is_end = s_axis_tlast_i || (s_axis_tdata_i == CHAR_NUL);

  always_comb begin
    priority if (mode_q == MODE_XWAIT) begin
      close_err = FERR_DIGIT;
    end else if ((mode_q != MODE_BAD) && (value_q > OCTET_MAX)) begin
      close_err = FERR_RANGE;
    end else begin
      close_err = FERR_NONE;
    end
  end

  assign ferr_close = (ferr_q != FERR_NONE) ? ferr_q : close_err;
  assign sf_end = sf_q || (chars_q == '0) || (fn_q != 2'd3);

  always_comb begin
    priority if (sf_end) begin
      kind = KIND_STRUCT;
    end else if (ferr_close == FERR_LEAD) begin
      kind = KIND_LEAD;
    end else if (ferr_close == FERR_DIGIT) begin
      kind = KIND_DIGIT;
    end else if (ferr_close == FERR_RANGE) begin
      kind = KIND_RANGE;
    end else begin
      kind = KIND_OK;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      oct_out[i] = (kind == KIND_OK) ? oct_q[i] : 8'd0;
    end
    oct_out[3] = (kind == KIND_OK) ? value_q[7:0] : 8'd0;
  end

  always_comb begin
    fn_d        = fn_q;
    chars_d     = chars_q;
    sf_d        = sf_q;
    ferr_d      = ferr_q;
    mode_d      = mode_q;
    value_d     = value_q;
    oct_d       = oct_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d  = out_data_q;
    if (accept) begin
      if (is_end) begin
        out_valid_d = 1'b1;
        out_data_d  = {4'b0000, oct_out[3], oct_out[2], oct_out[1], oct_out[0],
                       kind, (kind == KIND_OK)};
        fn_d        = '0;
        chars_d     = '0;
        sf_d        = 1'b0;
        ferr_d      = FERR_NONE;
        mode_d      = MODE_START;
        value_d     = '0;
        for (int i = 0; i < 4; i++) begin
          oct_d[i] = 8'd0;
        end
      end else if (!sf_q) begin
        priority if (s_axis_tdata_i == CHAR_DOT) begin
          if ((chars_q == '0) || (fn_q == 2'd3)) begin
            sf_d = 1'b1;
          end else begin
            if (mode_q == MODE_XWAIT) begin
              mode_d = MODE_BAD;
            end
            ferr_d      = ferr_close;
            oct_d[fn_q] = value_q[7:0];
            fn_d        = fn_q + 2'd1;
            chars_d     = '0;
            mode_d      = MODE_START;
            value_d     = '0;
          end
        end else if (chars_q >= CHAR_CNT_W'(MAX_FIELD_CHARS)) begin
          sf_d = 1'b1;
        end else begin
          chars_d = chars_q + CHAR_CNT_W'(1);
          mode_d  = step.mode;
          value_d = step.value;
          ferr_d  = (ferr_q != FERR_NONE) ? ferr_q : step.err;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fn_q        <= '0;
      chars_q     <= '0;
      sf_q        <= 1'b0;
      ferr_q      <= FERR_NONE;
      mode_q      <= MODE_START;
      value_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        oct_q[i] <= 8'd0;
      end
    end else begin
      fn_q        <= fn_d;
      chars_q     <= chars_d;
      sf_q        <= sf_d;
      ferr_q      <= ferr_d;
      mode_q      <= mode_d;
      value_q     <= value_d;
      out_valid_q <= out_valid_d;
      oct_q       <= oct_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

[sv/ipv4dq_checker.sv]
// Port-level assertions for the dotted-quad address checker, bound to its top level.
// Depends on ipv4_dotted_quad_checker_macros.svh.
`include "ipv4_dotted_quad_checker_macros.svh"

module ipv4dq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [7:0]  s_axis_tdata_i,
  input logic        s_axis_tlast_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o
);

  // A stalled result transaction keeps its payload.
  `IPV4DQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o))

  // An accepted transaction with tlast always produces a verdict in the next cycle.
  `IPV4DQ_ASSERT_NEXT(a_end_gives_verdict, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i, m_axis_tvalid_o)

  // A valid address carries error kind zero and no pad bits.
  `IPV4DQ_ASSERT_SAME(a_valid_kind, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tdata_o[0], (m_axis_tdata_o[3:1] == 3'd0) && (m_axis_tdata_o[39:36] == 4'd0))

  // An invalid address has a nonzero, known error kind and all octets zero.
  `IPV4DQ_ASSERT_SAME(a_invalid_zero, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tdata_o[0], (m_axis_tdata_o[3:1] != 3'd0) && (m_axis_tdata_o[3:1] <= 3'd4) && (m_axis_tdata_o[39:4] == 36'd0))

  // Input is never refused while no verdict waits.
  `IPV4DQ_ASSERT_SAME(a_ready_when_empty, clk_i, rst_ni, !m_axis_tvalid_o, s_axis_tready_o)

endmodule

bind ipv4_dotted_quad_checker ipv4dq_checker u_ipv4dq_checker (.*);

[bench/ipv4dq_verdict_checker.sv]
// Checker for the dotted-quad address checker: watches both stream channels, parses
// the accepted characters itself and compares every verdict with its own prediction.
// Depends on ipv4dq_pkg.
module ipv4dq_verdict_checker import ipv4dq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,
  input  logic        s_tlast_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [39:0] m_tdata_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o,
  output int          valid_seen_o
);

  typedef struct packed {
    logic            ok;
    kind_e           kind;
    logic [3:0][7:0] octet;
  } verdict_t;

  verdict_t expected_verdicts[$];

  int unsigned     field_idx;
  int unsigned     field_chars;
  bit              structure_bad;
  ferr_e           first_err;
  mode_e           mode;
  int unsigned     acc;
  logic [3:0][7:0] octets;

  function automatic void open_field();
    field_chars = 0;
    mode = MODE_START;
    acc = 0;
  endfunction

  function automatic void clear_parse();
    field_idx = 0;
    structure_bad = 1'b0;
    first_err = FERR_NONE;
    octets = '0;
    open_field();
  endfunction

  function automatic void field_error(ferr_e e);
    if (first_err == FERR_NONE) first_err = e;
  endfunction

  function automatic void bad_digit();
    mode = MODE_BAD;
    field_error(FERR_DIGIT);
  endfunction

  function automatic void add_digit(int unsigned base, int unsigned digit);
    int unsigned t;
    t = acc * base + digit;
    acc = (t > VALUE_CAP) ? VALUE_CAP : t;
  endfunction

  function automatic int hex_value(logic [7:0] c);
    if (c >= CHAR_0 && c <= CHAR_9) return c - CHAR_0;
    if (c >= CHAR_LA && c <= CHAR_LF) return c - CHAR_LA + 10;
    if (c >= CHAR_UA && c <= CHAR_UF) return c - CHAR_UA + 10;
    return -1;
  endfunction

  function automatic void eat_char(logic [7:0] c);
    int hv;
    hv = hex_value(c);
    case (mode)
      MODE_START: begin
        if (c == CHAR_0) begin
          mode = MODE_ZERO;
          acc = 0;
        end else if (c >= CHAR_1 && c <= CHAR_9) begin
          mode = MODE_DEC;
          acc = c - CHAR_0;
        end else begin
          mode = MODE_BAD;
          field_error(FERR_LEAD);
        end
      end
      MODE_ZERO: begin
        if (c == CHAR_LX || c == CHAR_UX) begin
          mode = MODE_XWAIT;
        end else if (c >= CHAR_0 && c <= CHAR_7) begin
          mode = MODE_OCT;
          add_digit(8, c - CHAR_0);
        end else begin
          bad_digit();
        end
      end
      MODE_XWAIT: begin
        if (hv >= 0) begin
          mode = MODE_HEX;
          add_digit(16, hv);
        end else begin
          bad_digit();
        end
      end
      MODE_HEX: begin
        if (hv >= 0) add_digit(16, hv);
        else bad_digit();
      end
      MODE_OCT: begin
        if (c >= CHAR_0 && c <= CHAR_7) add_digit(8, c - CHAR_0);
        else bad_digit();
      end
      MODE_DEC: begin
        if (c >= CHAR_0 && c <= CHAR_9) add_digit(10, c - CHAR_0);
        else bad_digit();
      end
      default: ;
    endcase
  endfunction

  function automatic void close_field();
    if (mode == MODE_XWAIT) bad_digit();
    else if (mode != MODE_BAD && acc > OCTET_MAX) field_error(FERR_RANGE);
    octets[field_idx] = acc[7:0];
  endfunction

  function automatic void parse_transaction(logic [7:0] c, logic last);
    verdict_t v;
    if (!(last || c == CHAR_NUL)) begin
      if (structure_bad) return;
      if (c == CHAR_DOT) begin
        if (field_chars == 0 || field_idx >= 3) begin
          structure_bad = 1'b1;
        end else begin
          close_field();
          field_idx++;
          open_field();
        end
      end else if (field_chars >= MAX_FIELD_CHARS) begin
        structure_bad = 1'b1;
      end else begin
        field_chars++;
        eat_char(c);
      end
      return;
    end
    if (!structure_bad) begin
      if (field_chars == 0 || field_idx != 3) structure_bad = 1'b1;
      else close_field();
    end
    if (structure_bad) begin
      v.kind = KIND_STRUCT;
    end else begin
      case (first_err)
        FERR_LEAD:  v.kind = KIND_LEAD;
        FERR_DIGIT: v.kind = KIND_DIGIT;
        FERR_RANGE: v.kind = KIND_RANGE;
        default:    v.kind = KIND_OK;
      endcase
    end
    v.ok = (v.kind == KIND_OK);
    v.octet = v.ok ? octets : '0;
    expected_verdicts.push_back(v);
    clear_parse();
  endfunction

  task automatic report_mismatch(string what, logic [39:0] got, logic [39:0] want);
    fail_count_o++;
    if (fail_count_o <= 40)
      $display("Verdict %0d, %s: got 0x%0h, expected 0x%0h", checked_o + 1, what, got, want);
  endtask

  task automatic check_verdict(logic [39:0] d);
    verdict_t want;
    if (expected_verdicts.size() == 0) begin
      report_mismatch("verdict with no string closed", d, '0);
      return;
    end
    want = expected_verdicts.pop_front();
    if (d[0] !== want.ok) report_mismatch("is_valid", d[0], want.ok);
    if (d[3:1] !== want.kind) report_mismatch("error_kind", d[3:1], want.kind);
    for (int i = 0; i < 4; i++) begin
      if (d[4 + 8 * i +: 8] !== want.octet[i])
        report_mismatch($sformatf("octet %0d", i + 1), d[4 + 8 * i +: 8], want.octet[i]);
    end
    if (d[39:36] !== 4'b0) report_mismatch("pad bits", d[39:36], '0);
    checked_o++;
    if (want.ok) valid_seen_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_verdicts.delete();
      clear_parse();
      fail_count_o = 0;
      pending_o = 0;
      checked_o = 0;
      valid_seen_o = 0;
    end else begin
      if (s_tvalid_i && s_tready_i) parse_transaction(s_tdata_i, s_tlast_i);
      if (m_tvalid_i && m_tready_i) check_verdict(m_tdata_i);
      pending_o = expected_verdicts.size();
    end
  end

endmodule

[bench/tb_ipv4_dotted_quad_checker.sv]
// Testbench top of the dotted-quad address checker: clock, reset, address strings
// and receiver stalls, with the verdict checker instantiated beside the block.
// Depends on ipv4dq_pkg, ipv4_dotted_quad_checker and ipv4dq_verdict_checker.
module tb_ipv4_dotted_quad_checker import ipv4dq_pkg::*; ();

  localparam int CHAR_TARGET = 1250;
  localparam int CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;

  int fail_count;
  int pending;
  int checked;
  int valid_seen;
  int cycles = 0;
  int burst_left = 0;
  bit steady = 1'b0;
  int transactions_sent = 0;
  int strings_sent = 0;
  int directed_sent;

  ipv4_dotted_quad_checker dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  ipv4dq_verdict_checker verdicts (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_axis_tvalid_i),
    .s_tready_i   (s_axis_tready_o),
    .s_tdata_i    (s_axis_tdata_i),
    .s_tlast_i    (s_axis_tlast_i),
    .m_tvalid_i   (m_axis_tvalid_o),
    .m_tready_i   (m_axis_tready_i),
    .m_tdata_i    (m_axis_tdata_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .valid_seen_o (valid_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_ipv4_dotted_quad_checker: FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    case ((cycles / 256) % 4)
      0:       m_axis_tready_i = 1'b1;
      1:       m_axis_tready_i = ($urandom_range(0, 1) == 1);
      2:       m_axis_tready_i = ($urandom_range(0, 3) == 0);
      default: m_axis_tready_i = ((cycles % 7) < 3);
    endcase
  end

  task automatic put_byte(logic [7:0] code, logic last);
    int gap;
    if (!steady && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      s_axis_tvalid_i = 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk);
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i = code;
    s_axis_tlast_i = last;
    @(posedge clk);
    while (!s_axis_tready_o) @(posedge clk);
    if (burst_left > 0) burst_left--;
    transactions_sent++;
  endtask

  task automatic send_text(string s, bit nul_end);
    for (int i = 0; i < s.len(); i++) put_byte(s[i], 1'b0);
    if (nul_end) put_byte(CHAR_NUL, 1'b0);
    else put_byte(8'($urandom_range(0, 255)), 1'b1);
    strings_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid_i = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic byte odd_char();
    string pool;
    pool = "089afAFgGxX.:/ -";
    if ($urandom_range(0, 1)) return byte'($urandom_range(1, 255));
    return pool[$urandom_range(0, pool.len() - 1)];
  endfunction

  function automatic string make_field();
    int    pick;
    int    v;
    string f;
    pick = $urandom_range(0, 19);
    if (pick < 8) begin
      v = (pick == 0) ? $urandom_range(256, 999) : $urandom_range(0, 255);
      f = $sformatf("%0d", v);
    end else if (pick < 12) begin
      v = (pick == 8) ? $urandom_range(256, 511) : $urandom_range(0, 255);
      f = {"0", $sformatf("%0o", v)};
    end else if (pick < 16) begin
      v = $urandom_range(0, 255);
      f = (pick < 14) ? $sformatf("0x%0x", v) : $sformatf("0X%0X", v);
    end else if (pick == 16) begin
      f = "0";
    end else if (pick == 17) begin
      f = $urandom_range(0, 1) ? "0x" : "0X";
    end else begin
      f = $sformatf("%0d", $urandom_range(0, 255));
      f.putc($urandom_range(0, f.len() - 1), odd_char());
    end
    return f;
  endfunction

  function automatic string make_address();
    string f[5];
    string s;
    int    n;
    n = 4;
    for (int k = 0; k < 5; k++) f[k] = make_field();
    case ($urandom_range(0, 15))
      0:       n = 3;
      1:       n = 5;
      2:       f[$urandom_range(0, 3)] = "";
      3:       f[$urandom_range(0, 3)] = "12345";
      default: ;
    endcase
    s = f[0];
    for (int k = 1; k < n; k++) s = {s, ".", f[k]};
    if ($urandom_range(0, 31) == 0) s = {s, "."};
    return s;
  endfunction

  task automatic send_noise();
    int n;
    n = $urandom_range(0, 10);
    repeat (n) put_byte(8'($urandom_range(0, 255)), 1'b0);
    put_byte(8'($urandom_range(0, 255)), 1'b1);
    strings_sent++;
  endtask

  initial begin
    int n;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_text("1.2.3.4", 1'b0);
    send_text("0xff.0377.255.0", 1'b0);
    send_text("0X1F.0.00.9", 1'b1);
    send_text("", 1'b0);
    send_text("1..2.3", 1'b0);
    send_text(".1.2.3", 1'b0);
    send_text("1.2.3.", 1'b0);
    send_text("12345.1.1.1", 1'b0);
    send_text("1.2.3.4.5", 1'b0);
    send_text("0x.1.1.1", 1'b0);
    send_text("08.1.1.09", 1'b0);
    send_text("\377.1.1.1", 1'b0);
    send_text("256.1.1.0777", 1'b0);
    send_text("1.a.08.300", 1'b0);
    send_text("a.256.1.1.1x", 1'b0);
    send_text("9.8.7.6x", 1'b0);
    directed_sent = transactions_sent;
    wait_drained();

    n = 0;
    while (transactions_sent < CHAR_TARGET) begin
      steady = ((n % 60) >= 50);
      if (n == 100) wait_drained();
      if ($urandom_range(0, 9) == 0) send_noise();
      else send_text(make_address(), ($urandom_range(0, 7) == 0));
      n++;
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Sent %0d address strings in %0d transactions, %0d of them directed.",
             strings_sent, transactions_sent, directed_sent);
    $display("Checked %0d verdicts, %0d of them valid addresses.", checked, valid_seen);
    if (fail_count == 0) begin
      $display("tb_ipv4_dotted_quad_checker: PASS");
    end else begin
      $display("tb_ipv4_dotted_quad_checker: FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/ipv4dq_pkg.sv
sv/ipv4dq_field_parser.sv
sv/ipv4_dotted_quad_checker.sv
sv/ipv4dq_checker.sv
bench/ipv4dq_verdict_checker.sv
bench/tb_ipv4_dotted_quad_checker.sv
